### hdl/gbn_pkg.sv
`timescale 1ns / 1ps
package gbn_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_BOXES_DEF   = 64;
    localparam int COORD_WIDTH_DEF = 16;

    // Fixed field widths of the channels.
    localparam int FIELD_W = 16;
    localparam int CLASS_W = 5;
    localparam int ATTR_W  = 2 * FIELD_W + CLASS_W;

    // One coordinate unit (6 fraction bits) for the inclusive size convention.
    localparam int ONE_UNIT = 64;

    // Overlap threshold after reset (0.5).
    localparam logic [FIELD_W-1:0] IOU_THR_RESET = 16'd32768;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;

    // Per-item control bits handed from the front to the back.
    typedef struct packed {
        logic store;
        logic last;
        logic ovf;
    } t_ctrl;

    localparam int CTRL_W = $bits(t_ctrl);

endpackage

### hdl/gbn_box_if.sv
`timescale 1ns / 1ps
interface gbn_box_if;
    logic        valid;
    logic        ready;
    logic [15:0] left_x;
    logic [15:0] top_y;
    logic [15:0] right_x;
    logic [15:0] bottom_y;
    logic [15:0] box_score;
    logic [15:0] objectness;
    logic [4:0]  class_index;
    logic        last_box;

    modport source (
        output valid, left_x, top_y, right_x, bottom_y,
        output box_score, objectness, class_index, last_box,
        input  ready
    );
    modport sink (
        input  valid, left_x, top_y, right_x, bottom_y,
        input  box_score, objectness, class_index, last_box,
        output ready
    );
endinterface

### hdl/gbn_kept_if.sv
`timescale 1ns / 1ps
interface gbn_kept_if;
    logic        valid;
    logic        ready;
    logic [15:0] kept_left_x;
    logic [15:0] kept_top_y;
    logic [15:0] kept_right_x;
    logic [15:0] kept_bottom_y;
    logic [15:0] kept_score;
    logic [15:0] kept_objectness;
    logic [4:0]  kept_class;
    logic        last_kept;
    logic        overflowed;

    modport source (
        output valid, kept_left_x, kept_top_y, kept_right_x, kept_bottom_y,
        output kept_score, kept_objectness, kept_class, last_kept, overflowed,
        input  ready
    );
    modport sink (
        input  valid, kept_left_x, kept_top_y, kept_right_x, kept_bottom_y,
        input  kept_score, kept_objectness, kept_class, last_kept, overflowed,
        output ready
    );
endinterface

### hdl/gbn_queue.sv
`timescale 1ns / 1ps
module gbn_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    import gbn_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_slot [QUEUE_DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end
endmodule

### hdl/gbn_front.sv
`timescale 1ns / 1ps
module gbn_front #(
    parameter int MAX_BOXES   = gbn_pkg::MAX_BOXES_DEF,
    parameter int COORD_WIDTH = gbn_pkg::COORD_WIDTH_DEF,
    parameter int ENTRY_W     = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    gbn_box_if.sink            i_box,
    input  logic               i_q_full,
    output logic               o_q_push,
    output logic [ENTRY_W-1:0] o_q_entry
);
    import gbn_pkg::*;

    localparam int IW   = $clog2(MAX_BOXES);
    localparam int CNTW = $clog2(MAX_BOXES + 1);

    logic [CNTW-1:0]        r_count;
    logic                   r_ovf;
    logic [CNTW-1:0]        n_count;
    logic                   n_ovf;
    logic                   drop;
    logic [CNTW-1:0]        stored_n;
    t_ctrl                  ctrl;
    logic [31:0]            z_l;
    logic [31:0]            z_t;
    logic [31:0]            z_r;
    logic [31:0]            z_b;
    logic [COORD_WIDTH-1:0] c_l;
    logic [COORD_WIDTH-1:0] c_t;
    logic [COORD_WIDTH-1:0] c_r;
    logic [COORD_WIDTH-1:0] c_b;

    // Take the low coordinate bits; wider settings see the field zero-extended.
    assign z_l = {16'b0, i_box.left_x};
    assign z_t = {16'b0, i_box.top_y};
    assign z_r = {16'b0, i_box.right_x};
    assign z_b = {16'b0, i_box.bottom_y};
    assign c_l = z_l[COORD_WIDTH-1:0];
    assign c_t = z_t[COORD_WIDTH-1:0];
    assign c_r = z_r[COORD_WIDTH-1:0];
    assign c_b = z_b[COORD_WIDTH-1:0];

    // Classify the box: stored, or dropped beyond capacity.
    always_comb begin
        drop       = (r_count == CNTW'(MAX_BOXES));
        stored_n   = drop ? r_count : r_count + 1'b1;
        ctrl.store = !drop;
        ctrl.last  = i_box.last_box;
        ctrl.ovf   = r_ovf || drop;
        if (i_box.last_box) begin
            n_count = '0;
            n_ovf   = 1'b0;
        end else begin
            n_count = stored_n;
            n_ovf   = r_ovf || drop;
        end
    end

    assign i_box.ready = !i_q_full;
    assign o_q_push    = i_box.valid && !i_q_full;
    assign o_q_entry   = {c_l, c_t, c_r, c_b, i_box.box_score, i_box.objectness,
                          i_box.class_index, r_count[IW-1:0], stored_n, ctrl};

    // List position and overflow flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (o_q_push) begin
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end
endmodule

### hdl/gbn_back.sv
`timescale 1ns / 1ps
module gbn_back #(
    parameter int MAX_BOXES   = gbn_pkg::MAX_BOXES_DEF,
    parameter int COORD_WIDTH = gbn_pkg::COORD_WIDTH_DEF,
    parameter int ENTRY_W     = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [gbn_pkg::FIELD_W-1:0]    i_cfg_data,
    input  logic                           i_q_valid,
    input  logic [ENTRY_W-1:0]             i_q_entry,
    output logic                           o_q_pop,
    gbn_kept_if.source                     o_kept
);
    import gbn_pkg::*;

    localparam int CWD  = COORD_WIDTH;
    localparam int IW   = $clog2(MAX_BOXES);
    localparam int CNTW = $clog2(MAX_BOXES + 1);
    localparam int WD   = CWD + 2;
    localparam int PW   = 2 * WD;
    localparam int UW   = PW + 1;
    localparam int SW   = UW + FIELD_W;
    localparam int BW   = 4 * CWD;

    typedef enum logic [3:0] {
        S_LOAD, S_ROW_RD, S_ROW_CAP, S_PAIR_RD, S_PAIR_CAP, S_DIFF,
        S_MUL, S_UNION, S_SCALE, S_TEST, S_EMIT_RD, S_EMIT_CAP
    } t_state;

    logic [BW-1:0]     mem_coord [MAX_BOXES];
    logic [ATTR_W-1:0] mem_attr  [MAX_BOXES];
    logic              mem_supp  [MAX_BOXES];

    t_state            r_state;
    logic [FIELD_W-1:0] r_thr;
    logic [CNTW-1:0]   r_n;
    logic              r_ovf;
    logic [CNTW-1:0]   r_m;
    logic [CNTW-1:0]   r_k;
    logic [CNTW-1:0]   r_e;
    logic [CNTW-1:0]   r_lastk;
    logic [BW-1:0]     r_rd_coord;
    logic [ATTR_W-1:0] r_rd_attr;
    logic              r_rd_supp;
    logic [BW-1:0]     r_a;
    logic [BW-1:0]     r_b;

    logic signed [WD-1:0]  r_iw, r_ih, r_aw, r_ah, r_bw, r_bh;
    logic                  r_disj;
    logic signed [PW-1:0]  r_inter, r_ua, r_ub;
    logic signed [PW+1:0]  r_uni;
    logic [SW-1:0]         r_lhs, r_rhs;
    logic                  r_uzero, r_uneg;

    logic [IW-1:0]     rd_addr;
    logic              supp_we;
    logic [IW-1:0]     supp_addr;
    logic              supp_val;
    logic              load_we;
    t_ctrl             q_ctrl;
    logic [CNTW-1:0]   q_cnt;
    logic [IW-1:0]     q_idx;
    logic [ATTR_W-1:0] q_attr;
    logic [BW-1:0]     q_coord;
    logic              out_free;
    logic              emit;
    logic              suppress;

    logic signed [CWD-1:0] al, at, ar, ab, bl, bt, br, bb;
    logic signed [CWD-1:0] ix1, iy1, ix2, iy2;
    logic [31:0]           ox_l, ox_t, ox_r, ox_b;

    // Queue entry fields.
    assign q_ctrl  = i_q_entry[CTRL_W-1:0];
    assign q_cnt   = i_q_entry[CNTW+CTRL_W-1:CTRL_W];
    assign q_idx   = i_q_entry[IW+CNTW+CTRL_W-1:CNTW+CTRL_W];
    assign q_attr  = i_q_entry[ATTR_W+IW+CNTW+CTRL_W-1:IW+CNTW+CTRL_W];
    assign q_coord = i_q_entry[ENTRY_W-1:ENTRY_W-BW];

    assign o_q_pop  = (r_state == S_LOAD);
    assign load_we  = o_q_pop && i_q_valid && q_ctrl.store;
    assign out_free = !o_kept.valid || o_kept.ready;
    assign emit     = (r_state == S_EMIT_CAP) && !r_rd_supp && out_free;

    // Read address per phase.
    always_comb begin
        case (r_state)
            S_ROW_RD:                rd_addr = r_m[IW-1:0];
            S_PAIR_RD:               rd_addr = r_k[IW-1:0];
            S_EMIT_RD, S_EMIT_CAP:   rd_addr = r_e[IW-1:0];
            default:                 rd_addr = r_k[IW-1:0];
        endcase
    end

    // Suppression decision for the current pair.
    assign suppress = !r_disj && (r_uzero || (!r_uneg && (r_lhs > r_rhs)));

    always_comb begin
        supp_we   = 1'b0;
        supp_addr = r_k[IW-1:0];
        supp_val  = 1'b1;
        if (load_we) begin
            supp_we   = 1'b1;
            supp_addr = q_idx;
            supp_val  = 1'b0;
        end else if (r_state == S_TEST && suppress) begin
            supp_we = 1'b1;
        end
    end

    // Box storage with registered reads.
    always_ff @(posedge i_clk) begin
        if (load_we) begin
            mem_coord[q_idx] <= q_coord;
            mem_attr[q_idx]  <= q_attr;
        end
        if (supp_we) begin
            mem_supp[supp_addr] <= supp_val;
        end
        r_rd_coord <= mem_coord[rd_addr];
        r_rd_attr  <= mem_attr[rd_addr];
        r_rd_supp  <= mem_supp[rd_addr];
    end

    // Pair geometry.
    always_comb begin
        al  = signed'(r_a[4*CWD-1:3*CWD]);
        at  = signed'(r_a[3*CWD-1:2*CWD]);
        ar  = signed'(r_a[2*CWD-1:CWD]);
        ab  = signed'(r_a[CWD-1:0]);
        bl  = signed'(r_b[4*CWD-1:3*CWD]);
        bt  = signed'(r_b[3*CWD-1:2*CWD]);
        br  = signed'(r_b[2*CWD-1:CWD]);
        bb  = signed'(r_b[CWD-1:0]);
        ix1 = (al > bl) ? al : bl;
        iy1 = (at > bt) ? at : bt;
        ix2 = (ar < br) ? ar : br;
        iy2 = (ab < bb) ? ab : bb;
    end

    // Output coordinates: low field bits of the stored coordinate bits.
    assign ox_l = 32'(r_rd_coord[4*CWD-1:3*CWD]);
    assign ox_t = 32'(r_rd_coord[3*CWD-1:2*CWD]);
    assign ox_r = 32'(r_rd_coord[2*CWD-1:CWD]);
    assign ox_b = 32'(r_rd_coord[CWD-1:0]);

    // Sequencer for loading, pairwise suppression and emission.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_thr        <= IOU_THR_RESET;
            o_kept.valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_data;
            end
            // Result valid rises on a kept box and falls once the transfer is taken.
            if (emit) begin
                o_kept.valid <= 1'b1;
            end else if (o_kept.ready) begin
                o_kept.valid <= 1'b0;
            end
            case (r_state)
                S_LOAD: begin
                    if (i_q_valid && q_ctrl.last) begin
                        r_n     <= q_cnt;
                        r_ovf   <= q_ctrl.ovf;
                        r_m     <= '0;
                        r_state <= S_ROW_RD;
                    end
                end
                S_ROW_RD: begin
                    r_state <= S_ROW_CAP;
                end
                S_ROW_CAP: begin
                    if (!r_rd_supp) begin
                        r_lastk <= r_m;
                        r_a     <= r_rd_coord;
                    end
                    if (r_m + 1'b1 == r_n) begin
                        r_e     <= '0;
                        r_state <= S_EMIT_RD;
                    end else if (r_rd_supp) begin
                        r_m     <= r_m + 1'b1;
                        r_state <= S_ROW_RD;
                    end else begin
                        r_k     <= r_m + 1'b1;
                        r_state <= S_PAIR_RD;
                    end
                end
                S_PAIR_RD: begin
                    r_state <= S_PAIR_CAP;
                end
                S_PAIR_CAP: begin
                    if (!r_rd_supp) begin
                        r_b     <= r_rd_coord;
                        r_state <= S_DIFF;
                    end else if (r_k + 1'b1 == r_n) begin
                        r_m     <= r_m + 1'b1;
                        r_state <= S_ROW_RD;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_PAIR_RD;
                    end
                end
                S_DIFF: begin
                    r_disj  <= (iy1 >= iy2) || (ix1 >= ix2);
                    r_iw    <= WD'(ix2) - WD'(ix1) + WD'(ONE_UNIT);
                    r_ih    <= WD'(iy2) - WD'(iy1) + WD'(ONE_UNIT);
                    r_aw    <= WD'(ar) - WD'(al) + WD'(ONE_UNIT);
                    r_ah    <= WD'(ab) - WD'(at) + WD'(ONE_UNIT);
                    r_bw    <= WD'(br) - WD'(bl) + WD'(ONE_UNIT);
                    r_bh    <= WD'(bb) - WD'(bt) + WD'(ONE_UNIT);
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_inter <= PW'(r_iw) * PW'(r_ih);
                    r_ua    <= PW'(r_aw) * PW'(r_ah);
                    r_ub    <= PW'(r_bw) * PW'(r_bh);
                    r_state <= S_UNION;
                end
                S_UNION: begin
                    r_uni   <= (PW+2)'(r_ua) + (PW+2)'(r_ub) - (PW+2)'(r_inter);
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    r_uzero <= (r_uni == '0);
                    r_uneg  <= r_uni[PW+1];
                    r_lhs   <= SW'({r_inter[PW-1:0], 16'b0});
                    r_rhs   <= SW'(r_uni[UW-1:0]) * SW'(r_thr);
                    r_state <= S_TEST;
                end
                S_TEST: begin
                    if (r_k + 1'b1 == r_n) begin
                        r_m     <= r_m + 1'b1;
                        r_state <= S_ROW_RD;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_PAIR_RD;
                    end
                end
                S_EMIT_RD: begin
                    r_state <= S_EMIT_CAP;
                end
                S_EMIT_CAP: begin
                    if (r_rd_supp || out_free) begin
                        if (!r_rd_supp) begin
                            o_kept.kept_left_x     <= ox_l[15:0];
                            o_kept.kept_top_y      <= ox_t[15:0];
                            o_kept.kept_right_x    <= ox_r[15:0];
                            o_kept.kept_bottom_y   <= ox_b[15:0];
                            o_kept.kept_score      <= r_rd_attr[ATTR_W-1:ATTR_W-FIELD_W];
                            o_kept.kept_objectness <= r_rd_attr[CLASS_W+FIELD_W-1:CLASS_W];
                            o_kept.kept_class      <= r_rd_attr[CLASS_W-1:0];
                            o_kept.last_kept       <= (r_e == r_lastk);
                            o_kept.overflowed      <= r_ovf;
                        end
                        if (r_e + 1'b1 == r_n) begin
                            r_state <= S_LOAD;
                        end else begin
                            r_e     <= r_e + 1'b1;
                            r_state <= S_EMIT_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end
endmodule

### hdl/greedy_box_nms.sv
`timescale 1ns / 1ps
// Greedy box suppression by overlap. Boxes of one list arrive on i_box, sorted
// by descending score, one transfer per box; last_box marks the end of the list.
// A front stage assigns each box its list slot, drops boxes beyond MAX_BOXES
// (flagging the list as overflowed) and hands them through a short queue to the
// back end, which stores one box per cycle while it is loading. On the marked
// box the back end runs the pairwise tests on its single shared overlap
// datapath, then streams the kept boxes in list order on o_kept, the final one
// with last_kept set. Suppression walks the list rows, skips suppressed rows
// and candidates, and tests each live pair in steps (read, geometry, products,
// union, scaling, compare). Emission reads every stored box, suppressed ones
// included. The next list may be loaded into the queue while a list is
// processed; the queue fills and i_box.ready falls until the back end returns
// to loading. A receiver stall on o_kept holds the emission sweep; nothing is
// lost. i_cfg_we writes the threshold; write it only while the block is idle.
// Reset (i_rst_n low, synchronous) empties the list and the queue and restores
// the threshold to 0.5; no clearing pass is needed.
module greedy_box_nms #(
    parameter int MAX_BOXES   = gbn_pkg::MAX_BOXES_DEF,
    parameter int COORD_WIDTH = gbn_pkg::COORD_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [gbn_pkg::FIELD_W-1:0] i_cfg_data,
    gbn_box_if.sink                     i_box,
    gbn_kept_if.source                  o_kept
);
    import gbn_pkg::*;

    localparam int IW      = $clog2(MAX_BOXES);
    localparam int CNTW    = $clog2(MAX_BOXES + 1);
    localparam int ENTRY_W = 4 * COORD_WIDTH + ATTR_W + IW + CNTW + CTRL_W;

    logic               q_push;
    logic               q_full;
    logic [ENTRY_W-1:0] q_in;
    logic               q_pop;
    logic               q_valid;
    logic [ENTRY_W-1:0] q_out;

    gbn_front #(
        .MAX_BOXES   (MAX_BOXES),
        .COORD_WIDTH (COORD_WIDTH),
        .ENTRY_W     (ENTRY_W)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_box     (i_box),
        .i_q_full  (q_full),
        .o_q_push  (q_push),
        .o_q_entry (q_in)
    );

    gbn_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    gbn_back #(
        .MAX_BOXES   (MAX_BOXES),
        .COORD_WIDTH (COORD_WIDTH),
        .ENTRY_W     (ENTRY_W)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_q_valid  (q_valid),
        .i_q_entry  (q_out),
        .o_q_pop    (q_pop),
        .o_kept     (o_kept)
    );
endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import gbn_pkg::*;

    typedef struct {
        logic signed [15:0] lx, ty, rx, by;
        logic [15:0]        score, obj;
        logic [4:0]         cls;
        logic               last;
    } t_box;

    typedef struct {
        logic [15:0] lx, ty, rx, by, score, obj;
        logic [4:0]  cls;
        logic        last, ovf;
    } t_kept;

    // Greedy suppression predictor with its own list, mask and threshold.
    class nms_scoreboard;
        t_box        list[$];
        bit          dropped;
        logic [15:0] thr = IOU_THR_RESET;
        t_kept       pending[$];
        int          errors = 0;

        function bit overlaps(t_box a, t_box b);
            longint ix1, iy1, ix2, iy2, inter, ua, ub, uni;
            ix1 = (a.lx > b.lx) ? a.lx : b.lx;
            iy1 = (a.ty > b.ty) ? a.ty : b.ty;
            ix2 = (a.rx < b.rx) ? a.rx : b.rx;
            iy2 = (a.by < b.by) ? a.by : b.by;
            if (iy1 >= iy2 || ix1 >= ix2) return 0;
            inter = (ix2 - ix1 + ONE_UNIT) * (iy2 - iy1 + ONE_UNIT);
            ua = (longint'(a.rx) - a.lx + ONE_UNIT) * (longint'(a.by) - a.ty + ONE_UNIT);
            ub = (longint'(b.rx) - b.lx + ONE_UNIT) * (longint'(b.by) - b.ty + ONE_UNIT);
            uni = ua + ub - inter;
            // A zero union means an unbounded ratio; a negative one never suppresses.
            if (uni == 0) return 1;
            if (uni < 0) return 0;
            return (inter * 65536) > (longint'(thr) * uni);
        endfunction

        // Note one accepted box; the marked box runs suppression on the list.
        function void note_box(t_box b);
            bit    gone[$];
            int    kept_idx[$];
            t_kept k;
            if (list.size() < MAX_BOXES_DEF) list.insert(list.size(), b);
            else dropped = 1;
            if (!b.last) return;
            foreach (list[i]) gone.insert(gone.size(), 1'b0);
            foreach (list[m]) begin
                if (gone[m]) continue;
                kept_idx.insert(kept_idx.size(), m);
                for (int j = m + 1; j < list.size(); j++)
                    if (!gone[j] && overlaps(list[m], list[j])) gone[j] = 1;
            end
            foreach (kept_idx[i]) begin
                k.lx = list[kept_idx[i]].lx;  k.ty = list[kept_idx[i]].ty;
                k.rx = list[kept_idx[i]].rx;  k.by = list[kept_idx[i]].by;
                k.score = list[kept_idx[i]].score;
                k.obj = list[kept_idx[i]].obj;
                k.cls = list[kept_idx[i]].cls;
                k.last = (i == kept_idx.size() - 1);
                k.ovf = dropped;
                pending.insert(pending.size(), k);
            end
            list.delete();
            dropped = 0;
        endfunction

        function void field(string name, logic [15:0] e, logic [15:0] a);
            if (e !== a) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, e, a);
                errors++;
            end
        endfunction

        function void check_kept(t_kept a);
            t_kept e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected kept box, actual %p", $realtime, a);
                errors++;
                return;
            end
            e = pending.pop_front();
            field("kept_left_x", e.lx, a.lx);
            field("kept_top_y", e.ty, a.ty);
            field("kept_right_x", e.rx, a.rx);
            field("kept_bottom_y", e.by, a.by);
            field("kept_score", e.score, a.score);
            field("kept_objectness", e.obj, a.obj);
            field("kept_class", e.cls, a.cls);
            field("last_kept", e.last, a.last);
            field("overflowed", e.ovf, a.ovf);
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [FIELD_W-1:0] i_cfg_data = '0;

    gbn_box_if  box_ch();
    gbn_kept_if kept_ch();

    greedy_box_nms dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data), .i_box(box_ch.sink), .o_kept(kept_ch.source)
    );

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    nms_scoreboard sb = new();
    int send_idle = 0;
    int recv_idle = 0;
    int hold_cycles = 0;

    initial begin
        box_ch.valid = 0;
        box_ch.left_x = 0; box_ch.top_y = 0; box_ch.right_x = 0; box_ch.bottom_y = 0;
        box_ch.box_score = 0; box_ch.objectness = 0; box_ch.class_index = 0;
        box_ch.last_box = 0;
        kept_ch.ready = 0;
    end

    // Receiver: check each transfer, then choose ready for the next cycle.
    always @(posedge i_clk) begin
        t_kept a;
        if (i_rst_n && kept_ch.valid && kept_ch.ready) begin
            a.lx = kept_ch.kept_left_x;    a.ty = kept_ch.kept_top_y;
            a.rx = kept_ch.kept_right_x;   a.by = kept_ch.kept_bottom_y;
            a.score = kept_ch.kept_score;  a.obj = kept_ch.kept_objectness;
            a.cls = kept_ch.kept_class;    a.last = kept_ch.last_kept;
            a.ovf = kept_ch.overflowed;
            sb.check_kept(a);
        end
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            kept_ch.ready <= 0;
        end else begin
            kept_ch.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Called at a rising edge; valid stays high after the transfer so that
    // the next box can follow at once.
    task automatic send_box(t_box b);
        while ($urandom_range(99) < send_idle) begin
            box_ch.valid <= 0;
            @(posedge i_clk);
        end
        box_ch.valid <= 1;
        box_ch.left_x <= b.lx;     box_ch.top_y <= b.ty;
        box_ch.right_x <= b.rx;    box_ch.bottom_y <= b.by;
        box_ch.box_score <= b.score; box_ch.objectness <= b.obj;
        box_ch.class_index <= b.cls; box_ch.last_box <= b.last;
        do @(posedge i_clk); while (!box_ch.ready);
        sb.note_box(b);
    endtask

    function automatic t_box make_box(int cx, int cy, int spread, bit last);
        t_box b;
        int w, h;
        w = $urandom_range(spread);
        h = $urandom_range(spread);
        b.lx = 16'(cx + $urandom_range(spread / 4) - spread / 8);
        b.ty = 16'(cy + $urandom_range(spread / 4) - spread / 8);
        b.rx = 16'(b.lx + w);
        b.by = 16'(b.ty + h);
        b.score = 16'($urandom);
        b.obj = 16'($urandom);
        b.cls = 5'($urandom);
        b.last = last;
        if ($urandom_range(99) < 15) begin
            // Noise: any bit pattern, inverted boxes included.
            b.lx = 16'($urandom); b.ty = 16'($urandom);
            b.rx = 16'($urandom); b.by = 16'($urandom);
        end
        return b;
    endfunction

    task automatic send_list(int n);
        int cx, cy, spread;
        cx = $signed(16'($urandom)) / 2;
        cy = $signed(16'($urandom)) / 2;
        spread = ($urandom_range(1)) ? 400 : 8000;
        for (int i = 0; i < n; i++) send_box(make_box(cx, cy, spread, i == n - 1));
    endtask

    // Stop offering boxes, then wait until every expected result has been seen
    // and the emission sweep over suppressed entries has finished.
    task automatic wait_drained();
        box_ch.valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic write_thr(logic [15:0] v);
        wait_drained();
        @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.thr = v;
    endtask

    task automatic random_lists(int items);
        int sent, n;
        sent = 0;
        while (sent < items) begin
            n = ($urandom_range(99) < 3) ? $urandom_range(62, 67) : $urandom_range(1, 8);
            send_list(n);
            sent += n;
        end
    endtask

    function automatic t_box mk(int l, int t, int r, int bt, bit last);
        t_box b;
        b.lx = 16'(l); b.ty = 16'(t); b.rx = 16'(r); b.by = 16'(bt);
        b.score = 16'($urandom); b.obj = 16'($urandom); b.cls = 5'($urandom);
        b.last = last;
        return b;
    endfunction

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: identical, touching, disjoint, extremes, a single box.
        send_box(mk(0, 0, 640, 640, 0));
        send_box(mk(0, 0, 640, 640, 0));
        send_box(mk(640, 0, 1280, 640, 0));
        send_box(mk(100, 100, 700, 700, 0));
        send_box(mk(-32768, -32768, 32767, 32767, 0));
        send_box(mk(32767, 32767, -32768, -32768, 0));
        send_box(mk(-32768, -32768, -32000, -32000, 1));
        send_box(mk(5, 5, 5, 5, 1));
        begin
            t_box b;
            b = mk(0, 0, 0, 0, 1);
            b.score = 16'hFFFF; b.obj = 16'hFFFF; b.cls = 5'h1F;
            send_box(b);
            b = mk(1, 1, 2, 2, 1);
            b.score = 0; b.obj = 0; b.cls = 0;
            send_box(b);
        end

        // Phase one: sender idles lightly, receiver heavily, with a long hold-off.
        send_idle = 14; recv_idle = 51;
        write_thr(16'd0);
        hold_cycles = 3000;
        send_list(66);
        send_list(6);
        random_lists(80);

        write_thr(16'hFFFF);
        send_idle = 51; recv_idle = 14;
        send_list(64);
        random_lists(100);

        write_thr(16'($urandom));
        send_idle = 0; recv_idle = 0;
        random_lists(70);

        write_thr(16'd1);
        random_lists(30);

        write_thr(IOU_THR_RESET);
        random_lists(30);

        wait_drained();
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #50ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule

### sim.f
hdl/gbn_pkg.sv
hdl/gbn_box_if.sv
hdl/gbn_kept_if.sv
hdl/gbn_queue.sv
hdl/gbn_front.sv
hdl/gbn_back.sv
hdl/greedy_box_nms.sv
verif/tb_top.sv
